// ===== hw/rtl/positional_list_engine_core_macros.svh =====
// Assertion macros for the positional list engine.
// No dependencies.
`ifndef POSITIONAL_LIST_ENGINE_CORE_MACROS_SVH
`define POSITIONAL_LIST_ENGINE_CORE_MACROS_SVH
`ifndef SYNTH
`define PLE_ASSERT_IMPL(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define PLE_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PLE_ASSERT_IMPL(label, clk, rst, prop, msg)
`define PLE_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

// ===== hw/rtl/ple_pkg.sv =====
// Shared types and codes for the positional list engine.
// No dependencies.
package ple_pkg;
   localparam int CAPACITY = 64;   // list depth, bounded by the 7-bit position field

   localparam int MODE_W = 3;
   localparam int VAL_W  = 32;
   localparam int POS_W  = 7;
   localparam int STAT_W = 2;

   localparam logic [MODE_W-1:0] MODE_INSERT  = 3'd0;
   localparam logic [MODE_W-1:0] MODE_DELETE  = 3'd1;
   localparam logic [MODE_W-1:0] MODE_SEARCH  = 3'd2;
   localparam logic [MODE_W-1:0] MODE_DEL_ALL = 3'd3;
   localparam logic [MODE_W-1:0] MODE_QUERY   = 3'd4;

   localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
   localparam logic [STAT_W-1:0] STAT_BAD_POS   = 2'd1;
   localparam logic [STAT_W-1:0] STAT_FULL      = 2'd2;
   localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 2'd3;

   // controller -> datapath
   typedef struct packed {
      logic load;      // capture request
      logic scan_init; // set scan pointers
      logic scan_step; // one memory read/write step
      logic finish;    // commit length, build result
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic scan_done;
      logic needs_scan;
   } stat_type;
endpackage

// ===== hw/rtl/ple_if.sv =====
// Valid/ready channel interfaces for the positional list engine.
// Depends on ple_pkg.
interface ple_req_if;
   logic                      valid;
   logic                      ready;
   logic [ple_pkg::MODE_W-1:0] mode;
   logic signed [ple_pkg::VAL_W-1:0] value;
   logic [ple_pkg::POS_W-1:0]  position;
   modport source (output valid, mode, value, position, input ready);
   modport sink   (input valid, mode, value, position, output ready);
endinterface

interface ple_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [ple_pkg::STAT_W-1:0] status;
   logic [ple_pkg::POS_W-1:0]  found_position;
   logic signed [ple_pkg::VAL_W-1:0] removed_value;
   logic [ple_pkg::POS_W-1:0]  length;
   logic                       is_empty;
   modport source (output valid, status, found_position, removed_value, length, is_empty,
                   input ready);
   modport sink   (input valid, status, found_position, removed_value, length, is_empty,
                   output ready);
endinterface

// ===== hw/rtl/ple_ctrl.sv =====
// Sequencer for the positional list engine.
// Depends on ple_pkg.
module ple_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   input  ple_pkg::stat_type stat,
   output ple_pkg::cmd_type  cmd
);
   import ple_pkg::*;

   typedef enum logic [2:0] {S_IDLE, S_DECODE, S_SCAN, S_FINISH, S_RESP} state_type;
   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   // a new item is taken once the last result has left or is leaving
   assign req_ready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd = '0;
      state_in = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         S_IDLE: begin
            if (req_valid && req_ready) begin
               cmd.load = 1'b1;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            cmd.scan_init = 1'b1;
            state_in = stat.needs_scan ? S_SCAN : S_FINISH;
         end
         S_SCAN: begin
            cmd.scan_step = 1'b1;
            if (stat.scan_done) state_in = S_FINISH;
         end
         S_FINISH: begin
            cmd.finish = 1'b1;
            rsp_valid_in = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end
endmodule

// ===== hw/rtl/ple_dpath.sv =====
// List memory, scan pointers and result registers.
// Depends on ple_pkg.
module ple_dpath (
   input  logic                                   clock,
   input  logic                                   reset,
   input  ple_pkg::cmd_type                       cmd,
   output ple_pkg::stat_type                      stat,
   input  logic [ple_pkg::MODE_W-1:0]             req_mode,
   input  logic signed [ple_pkg::VAL_W-1:0]       req_value,
   input  logic [ple_pkg::POS_W-1:0]              req_position,
   output logic [ple_pkg::STAT_W-1:0]             rsp_status,
   output logic [ple_pkg::POS_W-1:0]              rsp_found_position,
   output logic signed [ple_pkg::VAL_W-1:0]       rsp_removed_value,
   output logic [$clog2(ple_pkg::CAPACITY+1)-1:0] rsp_length,
   output logic                                   rsp_is_empty
);
   import ple_pkg::*;

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY+1);

   logic [VAL_W-1:0] mem [CAPACITY];

   logic [MODE_W-1:0] mode_ff;
   logic [VAL_W-1:0]  val_ff;
   logic [CW:0]       pos_ff;   // position, one bit of headroom
   logic [CW-1:0]     count_ff, count_in;
   logic [CW-1:0]     rd_ff;    // slot being worked on
   logic [CW-1:0]     wr_ff;    // compaction index
   logic [CW-1:0]     end_ff;   // scan stop
   logic              phase_ff; // 0: read issued, 1: read data ready
   logic              ok_ff;    // request passed its check
   logic [STAT_W-1:0] stat_ff;
   logic [POS_W-1:0]  found_ff;
   logic [VAL_W-1:0]  rem_ff;
   logic [VAL_W-1:0]  rdata_ff; // registered memory read
   logic [STAT_W-1:0] rs_ff;
   logic [POS_W-1:0]  rf_ff;
   logic [VAL_W-1:0]  rr_ff;
   logic [CW-1:0]     rl_ff;
   logic [CW:0]       cnt_ext;

   logic [CW-1:0]     pos_m1;
   logic [CW-1:0]     rd_up;
   logic [CW-1:0]     rd_dn;
   logic              last_slot;
   logic              keep_item;
   logic              chk_ok;
   logic [STAT_W-1:0] chk_stat;
   logic              mem_we;
   logic [AW-1:0]     mem_waddr;
   logic [AW-1:0]     mem_raddr;
   logic [VAL_W-1:0]  mem_wdata;

   assign cnt_ext   = {1'b0, count_ff};
   assign pos_m1    = CW'(pos_ff - (CW+1)'(1));
   assign rd_up     = rd_ff + CW'(1);
   assign rd_dn     = rd_ff - CW'(1);
   assign last_slot = (rd_ff == end_ff);
   assign keep_item = (rdata_ff != val_ff);
   // insert walks down and copies from the slot below
   assign mem_raddr = (mode_ff == MODE_INSERT) ? rd_dn[AW-1:0] : rd_ff[AW-1:0];

   // request check, evaluated while decoding
   always_comb begin
      chk_stat = STAT_OK;
      chk_ok   = 1'b0;
      case (mode_ff)
         MODE_INSERT: begin
            if (pos_ff == '0 || pos_ff > cnt_ext + (CW+1)'(1)) chk_stat = STAT_BAD_POS;
            else if (cnt_ext >= (CW+1)'(CAPACITY)) chk_stat = STAT_FULL;
            else chk_ok = 1'b1;
         end
         MODE_DELETE: begin
            if (pos_ff == '0 || pos_ff > cnt_ext) chk_stat = STAT_BAD_POS;
            else chk_ok = 1'b1;
         end
         MODE_SEARCH, MODE_DEL_ALL: begin
            if (count_ff == '0) chk_stat = STAT_NOT_FOUND;
            else chk_ok = 1'b1;
         end
         default: ;
      endcase
   end

   always_comb begin
      stat.needs_scan = chk_ok;
      case (mode_ff)
         MODE_INSERT: stat.scan_done = last_slot;
         MODE_SEARCH: stat.scan_done = phase_ff && (last_slot || rdata_ff == val_ff);
         default:     stat.scan_done = phase_ff && last_slot;
      endcase
   end

   // single write port
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = rd_ff[AW-1:0];
      mem_wdata = rdata_ff;
      if (cmd.scan_step) begin
         case (mode_ff)
            MODE_INSERT: begin
               if (last_slot) begin
                  mem_we    = 1'b1;
                  mem_wdata = val_ff;
               end else if (phase_ff) begin
                  mem_we = 1'b1;
               end
            end
            MODE_DELETE: begin
               if (phase_ff && rd_ff != pos_m1) begin
                  mem_we    = 1'b1;
                  mem_waddr = rd_dn[AW-1:0];
               end
            end
            MODE_DEL_ALL: begin
               if (phase_ff && keep_item) begin
                  mem_we    = 1'b1;
                  mem_waddr = wr_ff[AW-1:0];
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_waddr] <= mem_wdata;
      rdata_ff <= mem[mem_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.finish) begin
         count_ff <= count_in;
      end
   end

   always_comb begin
      count_in = count_ff;
      if (ok_ff) begin
         case (mode_ff)
            MODE_INSERT:  count_in = count_ff + CW'(1);
            MODE_DELETE:  count_in = count_ff - CW'(1);
            MODE_DEL_ALL: count_in = wr_ff;
            default:      count_in = count_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mode_ff  <= req_mode;
         val_ff   <= req_value;
         pos_ff   <= (CW+1)'(req_position);
         found_ff <= '0;
         rem_ff   <= '0;
         stat_ff  <= STAT_OK;
      end
      if (cmd.scan_init) begin
         stat_ff  <= chk_stat;
         ok_ff    <= chk_ok;
         phase_ff <= 1'b0;
         wr_ff    <= '0;
         case (mode_ff)
            MODE_INSERT: begin
               rd_ff  <= count_ff;   // slot being filled
               end_ff <= pos_m1;     // stop at insertion slot
            end
            MODE_DELETE: begin
               rd_ff  <= pos_m1;
               end_ff <= count_ff - CW'(1);
            end
            default: begin
               rd_ff  <= '0;
               end_ff <= count_ff - CW'(1);
            end
         endcase
      end
      if (cmd.scan_step) begin
         phase_ff <= !phase_ff;
         case (mode_ff)
            MODE_INSERT: begin
               if (phase_ff) rd_ff <= rd_dn;
            end
            MODE_DELETE: begin
               if (phase_ff) begin
                  if (rd_ff == pos_m1) rem_ff <= rdata_ff;
                  rd_ff <= rd_up;
               end
            end
            MODE_SEARCH: begin
               if (phase_ff) begin
                  if (rdata_ff == val_ff) found_ff <= POS_W'(rd_ff) + POS_W'(1);
                  else if (last_slot) stat_ff <= STAT_NOT_FOUND;
                  rd_ff <= rd_up;
               end
            end
            MODE_DEL_ALL: begin
               if (phase_ff) begin
                  if (keep_item) wr_ff <= wr_ff + CW'(1);
                  if (last_slot && (wr_ff + CW'(keep_item)) == count_ff)
                     stat_ff <= STAT_NOT_FOUND;
                  rd_ff <= rd_up;
               end
            end
            default: ;
         endcase
      end
      if (cmd.finish) begin
         rs_ff <= stat_ff;
         rf_ff <= found_ff;
         rr_ff <= rem_ff;
         rl_ff <= count_in;
      end
   end

   assign rsp_status         = rs_ff;
   assign rsp_found_position = rf_ff;
   assign rsp_removed_value  = rr_ff;
   assign rsp_length         = rl_ff;
   assign rsp_is_empty       = (rl_ff == '0);
endmodule

// ===== hw/rtl/positional_list_engine_core.sv =====
// Positional list engine: ordered list of signed 32-bit items.
// Query, unused modes and rejected requests skip the scan; scans step through
// the entries (shift, search or compaction), insert with a final step for its write.
// One item in flight; a new item is taken as the last result leaves.
// Synchronous active-high reset empties the list; entry contents stay undefined.
`include "positional_list_engine_core_macros.svh"
module positional_list_engine_core (
   input  logic clock,
   input  logic reset,
   ple_req_if.sink   req,
   ple_rsp_if.source rsp
);
   import ple_pkg::*;

   localparam int CW = $clog2(CAPACITY+1);

   cmd_type  cmd;
   stat_type stat;
   logic [CW-1:0] len;
   logic          len_zero;
   logic          req_fire;
   logic          rsp_stall;

   // sequencer: handshake and step control
   ple_ctrl u_ctrl (
      .clock, .reset,
      .req_valid (req.valid), .req_ready (req.ready),
      .rsp_valid (rsp.valid), .rsp_ready (rsp.ready),
      .stat, .cmd
   );

   // datapath: list memory and result registers
   ple_dpath u_dpath (
      .clock, .reset, .cmd, .stat,
      .req_mode (req.mode), .req_value (req.value), .req_position (req.position),
      .rsp_status (rsp.status), .rsp_found_position (rsp.found_position),
      .rsp_removed_value (rsp.removed_value), .rsp_length (len),
      .rsp_is_empty (rsp.is_empty)
   );

   assign rsp.length = POS_W'(len);

   assign len_zero  = (len == '0);
   assign req_fire  = req.valid && req.ready;
   assign rsp_stall = rsp.valid && !rsp.ready;

   `PLE_ASSERT_IMPL(a_empty, clock, reset, rsp.valid |-> (rsp.is_empty == len_zero), "empty flag")
   `PLE_ASSERT_IMPL(a_hold, clock, reset, rsp_stall |=> rsp.valid, "result dropped")
   `PLE_ASSERT_IMPL(a_busy, clock, reset, req_fire |-> (!rsp.valid || rsp.ready), "busy accept")
   `PLE_ASSERT_IMPL(a_cap, clock, reset, rsp.valid |-> (len <= CW'(CAPACITY)), "length overflow")
   `PLE_ASSERT_ALWAYS(a_rst, clock, reset |=> !rsp.valid, "valid after reset")
endmodule

// ===== test/tb.sv =====
// Testbench for positional_list_engine_core: ordered list insert/delete/search.
// Depends on ple_pkg and ple_if; predicts each result and checks it in order.
`timescale 1ns / 100ps
module tb;
   import ple_pkg::*;

   localparam int CAP = CAPACITY;
   localparam int CYCLE_LIMIT = 1000000;

   typedef struct packed {
      logic [STAT_W-1:0] status;
      logic [POS_W-1:0]  found_position;
      logic [VAL_W-1:0]  removed_value;
      logic [POS_W-1:0]  length;
      logic              is_empty;
   } answer_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   ple_req_if req ();
   ple_rsp_if rsp ();

   positional_list_engine_core dut (
      .clock(clock), .reset(reset), .req(req), .rsp(rsp)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Shadow list used to predict each answer.
   logic [VAL_W-1:0] shadow [CAP];
   int               shadow_len = 0;
   answer_type       pending_answers [$];

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   bit hold_rsp = 1'b0;
   int mismatches = 0;
   int cycles = 0;

   // Carry out one request on the shadow list and queue the answer.
   function automatic void predict_list_op(logic [MODE_W-1:0] mode,
                                           logic [VAL_W-1:0] value,
                                           logic [POS_W-1:0] position);
      answer_type a;
      int         j;
      a = '0;
      case (mode)
         MODE_INSERT: begin
            if (position < 1 || position > shadow_len + 1)
               a.status = STAT_BAD_POS;
            else if (shadow_len >= CAP)
               a.status = STAT_FULL;
            else begin
               for (int i = shadow_len; i >= position; i--)
                  shadow[i] = shadow[i-1];
               shadow[position-1] = value;
               shadow_len++;
            end
         end
         MODE_DELETE: begin
            if (position < 1 || position > shadow_len)
               a.status = STAT_BAD_POS;
            else begin
               a.removed_value = shadow[position-1];
               for (int i = position - 1; i + 1 < shadow_len; i++)
                  shadow[i] = shadow[i+1];
               shadow_len--;
            end
         end
         MODE_SEARCH: begin
            for (int i = 0; i < shadow_len; i++)
               if (a.found_position == 0 && shadow[i] == value)
                  a.found_position = POS_W'(i + 1);
            if (a.found_position == 0) a.status = STAT_NOT_FOUND;
         end
         MODE_DEL_ALL: begin
            j = 0;
            for (int i = 0; i < shadow_len; i++)
               if (shadow[i] != value) begin
                  shadow[j] = shadow[i];
                  j++;
               end
            if (j == shadow_len) a.status = STAT_NOT_FOUND;
            shadow_len = j;
         end
         default: ;
      endcase
      a.length   = POS_W'(shadow_len);
      a.is_empty = (shadow_len == 0);
      pending_answers.push_back(a);
   endfunction

   // Offer one item at the falling edge, hold it until accepted.
   task automatic send_item(logic [MODE_W-1:0] mode, logic [VAL_W-1:0] value,
                            logic [POS_W-1:0] position);
      while ($urandom_range(99) < send_idle_pct) begin
         req.valid <= 1'b0;
         @(negedge clock);
      end
      req.valid    <= 1'b1;
      req.mode     <= mode;
      req.value    <= value;
      req.position <= position;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      predict_list_op(mode, value, position);
      @(negedge clock);
   endtask

   // Receiver side: random backpressure, plus a long hold when asked.
   always @(negedge clock) begin
      if (reset) rsp.ready <= 1'b0;
      else rsp.ready <= !hold_rsp && ($urandom_range(99) >= recv_idle_pct);
   end

   // Compare each accepted answer with the oldest prediction.
   always @(posedge clock) begin
      answer_type want, got;
      cycles++;
      if (!reset && rsp.valid && rsp.ready) begin
         got = '{rsp.status, rsp.found_position, rsp.removed_value,
                 rsp.length, rsp.is_empty};
         if (pending_answers.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected answer %p", got);
         end else begin
            want = pending_answers.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected %p actual %p", want, got);
            end
         end
      end
      if (cycles > CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   // Small value pool so searches and delete-alls hit often.
   function automatic logic [VAL_W-1:0] pick_value();
      case ($urandom_range(3))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return VAL_W'($urandom_range(7));
         default: return $urandom;
      endcase
   endfunction

   task automatic test_directed();
      send_item(MODE_QUERY, 0, 0);
      send_item(MODE_DELETE, 0, 1);            // delete from empty list
      send_item(MODE_INSERT, 5, 0);            // position zero
      send_item(MODE_INSERT, 5, 2);            // past the end
      send_item(MODE_INSERT, 32'h8000_0000, 1);
      send_item(MODE_INSERT, 32'h7fff_ffff, 2);
      send_item(MODE_INSERT, 32'hffff_ffff, 1);
      send_item(MODE_INSERT, 32'h7fff_ffff, 2);
      send_item(MODE_SEARCH, 32'h7fff_ffff, 0);
      send_item(MODE_SEARCH, 32'h1234_5678, 0); // no match
      send_item(MODE_DELETE, 0, 5);             // past the end
      send_item(MODE_DELETE, 0, 127);
      send_item(MODE_DELETE, 0, 2);
      send_item(MODE_DEL_ALL, 32'h7fff_ffff, 0);
      send_item(MODE_DEL_ALL, 32'h7fff_ffff, 0); // none left
      send_item(3'd5, 32'hffff_ffff, 7'h7f);
      send_item(3'd6, 0, 0);
      send_item(3'd7, 0, 0);
      send_item(MODE_DELETE, 0, 1);
      send_item(MODE_DELETE, 0, 1);
      send_item(MODE_QUERY, 0, 0);
   endtask

   // Fill to capacity, then probe the full and bad-position checks.
   task automatic test_full_list();
      while (shadow_len < CAP)
         send_item(MODE_INSERT, pick_value(), POS_W'($urandom_range(shadow_len + 1, 1)));
      send_item(MODE_INSERT, 1, 1);
      send_item(MODE_INSERT, 1, POS_W'(CAP + 1));
      send_item(MODE_INSERT, 1, POS_W'(CAP + 2));
      send_item(MODE_DELETE, 0, POS_W'(CAP));
      send_item(MODE_INSERT, 9, POS_W'(CAP));
      send_item(MODE_DEL_ALL, 32'h7fff_ffff, 0);
      send_item(MODE_DEL_ALL, 32'h8000_0000, 0);
   endtask

   // Mostly valid operations, some with random fields.
   task automatic test_random(int count);
      logic [MODE_W-1:0] m;
      logic [POS_W-1:0]  p;
      for (int n = 0; n < count; n++) begin
         m = ($urandom_range(9) == 0) ? MODE_W'($urandom) : MODE_W'($urandom_range(4));
         if ($urandom_range(9) == 0) p = POS_W'($urandom);
         else if (m == MODE_INSERT && $urandom_range(2) != 0)
            p = POS_W'($urandom_range(shadow_len + 1, 1));
         else p = POS_W'($urandom_range(shadow_len > 0 ? shadow_len : 1, 1));
         // Bias toward inserts while short so the list grows deep.
         if (shadow_len < 20 && $urandom_range(1) == 0) m = MODE_INSERT;
         send_item(m, ($urandom_range(7) == 0) ? $urandom : pick_value(), p);
      end
   endtask

   // Receiver holds off while the sender keeps offering items.
   task automatic test_backpressure();
      hold_rsp = 1'b1;
      fork
         repeat (200) @(posedge clock);
         test_random(6);
      join_any
      hold_rsp = 1'b0;
      wait fork;
   endtask

   initial begin
      req.valid = 1'b0;
      req.mode = '0;
      req.value = '0;
      req.position = '0;
      repeat (2) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      send_idle_pct = 27; recv_idle_pct = 87;
      test_directed();
      test_full_list();
      test_random(300);
      send_idle_pct = 87; recv_idle_pct = 27;
      test_random(300);
      send_idle_pct = 0; recv_idle_pct = 0;
      test_backpressure();
      test_random(240);
      req.valid <= 1'b0;

      while (pending_answers.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (mismatches == 0 && pending_answers.size() == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end
endmodule
